### design/wls_pkg.sv
// Package for the 1D leapfrog wave stepper: item structs, codes, states,
// the control struct between sequencer and datapath, and saturation.
// Depends on nothing; every other design file imports it.
package wls_pkg;

    localparam int MESH_CELLS = 64;
    localparam int MIN_CELLS  = 3;
    localparam int IDX_W      = $clog2(MESH_CELLS);
    localparam int CNT_W      = $clog2(MESH_CELLS + 1);
    localparam int VAL_W      = 32;
    localparam int SPD_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic [1:0] MODE_DIRICHLET = 2'd0;
    localparam logic [1:0] MODE_NEUMANN   = 2'd1;
    localparam logic [1:0] MODE_MUR       = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CELLS_IN_USE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COURANT_SQ   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MUR_RATIO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_MODE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MODE   = 3'd5;

    typedef struct packed {
        logic                    command;
        logic [IDX_W-1:0]        cell_index;
        logic signed [VAL_W-1:0] displacement;
        logic signed [VAL_W-1:0] initial_velocity;
        logic [SPD_W-1:0]        node_speed_sq;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]        out_index;
        logic signed [VAL_W-1:0] new_value;
        logic                    last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRIME,
        ST_LOAD0,
        ST_FETCH,
        ST_MUL,
        ST_FLUX,
        ST_SCALE,
        ST_SUM,
        ST_SAT,
        ST_MUR0,
        ST_MUR1,
        ST_MUR2,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic prime;
        logic mul;
        logic flux;
        logic scale;
        logic sum;
        logic sat;
        logic zero_nv;
        logic mur0;
        logic mur1;
        logic load_mur;
        logic keep_prev;
        logic shift;
        logic first;
        logic mir_left;
        logic mir_right;
        logic mur_right;
    } t_calc_ctl;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [47:0] v);
        logic signed [VAL_W-1:0] res;
        if (v > 48'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -48'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[VAL_W-1:0];
        end
        return res;
    endfunction

endpackage

### design/wls_ram.sv
// Single-port-write, single-port-read memory with a registered read.
// Depth comes from wls_pkg; the word width is a parameter.
module wls_ram
    import wls_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [MESH_CELLS];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/wls_calc.sv
// Cell datapath: three-cell window, flux products, Courant scaling,
// leapfrog or start update with saturation, and the Mur boundary unit.
// Depends on wls_pkg; sequenced by the top level through t_calc_ctl.
module wls_calc
    import wls_pkg::*;
(
    input  logic                    i_clk,
    input  t_calc_ctl               i_ctl,
    input  logic [16:0]             i_courant_sq,
    input  logic [15:0]             i_time_step,
    input  logic signed [17:0]      i_mur_ratio,
    input  logic signed [VAL_W-1:0] i_cur_q,
    input  logic [SPD_W-1:0]        i_spd_q,
    input  logic signed [VAL_W-1:0] i_old_q,
    input  logic signed [VAL_W-1:0] i_vel_q,
    output logic signed [VAL_W-1:0] o_nv,
    output logic signed [VAL_W-1:0] o_mur_val,
    output logic signed [VAL_W-1:0] o_cell_u
);

    logic signed [VAL_W-1:0] r_um, r_u, r_up, r_w, r_nv, r_prev;
    logic [SPD_W-1:0]        r_sm, r_s, r_sp;
    logic signed [50:0]      r_a, r_b, r_mp;
    logic signed [48:0]      r_dtv;
    logic signed [51:0]      r_f;
    logic signed [32:0]      r_dtvr, r_d;
    logic signed [35:0]      r_base;
    logic [41:0]             r_plo;
    logic signed [44:0]      r_phi;
    logic signed [47:0]      r_t;

    logic signed [VAL_W-1:0] um_e, up_e, src, endv, mbase;
    logic [SPD_W-1:0]        sm_e, sp_e;
    logic signed [17:0]      sum_l, sum_r;
    logic signed [32:0]      diff_l, diff_r;
    logic signed [50:0]      a_prod, b_prod, mp_r;
    logic signed [48:0]      dtv, dtv_sum;
    logic signed [69:0]      full;
    logic signed [47:0]      total;
    logic signed [34:0]      mur_rr;

    always_comb begin
        // Neumann ends mirror the inner neighbor onto the missing one.
        um_e   = i_ctl.mir_left  ? i_cur_q : r_um;
        sm_e   = i_ctl.mir_left  ? i_spd_q : r_sm;
        up_e   = i_ctl.mir_right ? r_um    : i_cur_q;
        sp_e   = i_ctl.mir_right ? r_sm    : i_spd_q;
        sum_l  = $signed({2'b00, sm_e} + {2'b00, r_s});
        sum_r  = $signed({2'b00, r_s} + {2'b00, sp_e});
        diff_l = 33'(r_u) - 33'(um_e);
        diff_r = 33'(up_e) - 33'(r_u);
        a_prod = 51'(sum_l) * 51'(diff_l);
        b_prod = 51'(sum_r) * 51'(diff_r);
        dtv    = 49'($signed({1'b0, i_time_step})) * 49'(i_vel_q);
        dtv_sum = r_dtv + 49'sd32768;
        full   = (70'(r_phi) <<< 25) + 70'($signed({1'b0, r_plo}))
               + (i_ctl.first ? 70'sd33554432 : 70'sd16777216);
        total  = 48'(r_base) + r_t;
        src    = i_ctl.mur_right ? r_prev : r_nv;
        endv   = i_ctl.mur_right ? r_u    : r_um;
        mbase  = i_ctl.mur_right ? r_um   : r_u;
        mp_r   = r_mp + 51'sd32768;
        mur_rr = $signed(mp_r[50:16]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.prime) begin
            r_u <= i_cur_q;
            r_s <= i_spd_q;
        end
        if (i_ctl.mul) begin
            r_up  <= i_cur_q;
            r_sp  <= i_spd_q;
            r_w   <= i_old_q;
            r_a   <= a_prod;
            r_b   <= b_prod;
            r_dtv <= dtv;
        end
        if (i_ctl.flux) begin
            r_f    <= 52'(r_b) - 52'(r_a);
            r_dtvr <= $signed(dtv_sum[48:16]);
        end
        if (i_ctl.scale) begin
            r_plo <= 42'(i_courant_sq) * 42'(r_f[24:0]);
            r_phi <= 45'($signed({1'b0, i_courant_sq})) * 45'($signed(r_f[51:25]));
            if (i_ctl.first) begin
                r_base <= 36'(r_u) + 36'(r_dtvr);
            end else begin
                r_base <= (36'(r_u) <<< 1) - 36'(r_w);
            end
        end
        if (i_ctl.sum) begin
            if (i_ctl.first) begin
                r_t <= 48'($signed(full[69:26]));
            end else begin
                r_t <= 48'($signed(full[69:25]));
            end
        end
        if (i_ctl.sat) begin
            r_nv <= i_ctl.zero_nv ? '0 : sat32(total);
        end
        if (i_ctl.mur0) begin
            r_d <= 33'(src) - 33'(endv);
        end
        if (i_ctl.mur1) begin
            r_mp <= 51'(i_mur_ratio) * 51'(r_d);
        end
        if (i_ctl.load_mur) begin
            r_nv <= o_mur_val;
        end
        if (i_ctl.keep_prev) begin
            r_prev <= r_nv;
        end
        if (i_ctl.shift) begin
            r_um <= r_u;
            r_u  <= r_up;
            r_sm <= r_s;
            r_s  <= r_sp;
        end
    end

    assign o_mur_val = sat32(48'(mbase) + 48'(mur_rr));
    assign o_nv      = r_nv;
    assign o_cell_u  = r_u;

endmodule

### design/wave_1d_leapfrog_stepper.sv
// Top level of the 1D leapfrog wave stepper: configuration registers,
// the cell sequencer, the four level memories and the cell datapath.
// Depends on wls_pkg, wls_ram and wls_calc.
//
//   channel   direction  handshake                     payload
//   command   in         start high, busy low          i_item (t_in_item)
//   result    out        o_result_strobe, one cycle    o_result (t_out_item)
//   config    in         i_cfg_valid and o_cfg_ready   i_cfg_index, i_cfg_data
//
// A load transaction stores one cell and leaves busy low. A step transaction
// walks the cells in order, each through FETCH, MUL, FLUX, SCALE, SUM, SAT and
// EMIT, with MUR0 to MUR2 for each Mur boundary and PRIME and LOAD0 to prime
// the window. Results appear in the cycle after they are formed and cannot be
// held off. Reset clears the sequencer and the registers; the memories hold
// nothing defined until loaded, and no clearing pass is run.
module wave_1d_leapfrog_stepper
    import wls_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  t_in_item              i_item,
    output logic                  busy,
    output logic                  o_result_strobe,
    output t_out_item             o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers.
    logic [CNT_W-1:0]  r_cells;
    logic [16:0]       r_courant_sq;
    logic [15:0]       r_time_step;
    logic signed [17:0] r_mur_ratio;
    logic [1:0]        r_left_mode, r_right_mode;

    // Sequencer state.
    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_last_idx, n_last_idx;
    logic             r_started, n_started;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    t_calc_ctl        ctl;
    logic [CNT_W-1:0] cells_clamped;
    logic [CNT_W-1:0] cells_minus1;
    logic             left_neu, left_mur, right_neu, right_mur;
    logic             at_last, skip_emit;

    // Memory ports.
    logic                    cur_we, old_we, ld_we;
    logic [IDX_W-1:0]        cur_waddr, cur_raddr;
    logic signed [VAL_W-1:0] cur_wdata;
    logic [VAL_W-1:0]        cur_q, old_q, vel_q;
    logic [SPD_W-1:0]        spd_q;

    logic signed [VAL_W-1:0] calc_nv, calc_mur, calc_u;

    assign left_neu  = (r_left_mode  == MODE_NEUMANN);
    assign left_mur  = (r_left_mode  == MODE_MUR);
    assign right_neu = (r_right_mode == MODE_NEUMANN);
    assign right_mur = (r_right_mode == MODE_MUR);
    assign at_last   = (r_idx == r_last_idx);
    // With a Mur left end, cell 0 needs cell 1's new value, so cell 0 is
    // held back during its own slot and sent just ahead of cell 1.
    assign skip_emit = (r_idx == '0) && left_mur;

    // Out-of-range cell counts clamp to the supported mesh.
    always_comb begin
        if (r_cells < CNT_W'(MIN_CELLS)) begin
            cells_clamped = CNT_W'(MIN_CELLS);
        end else if (r_cells > CNT_W'(MESH_CELLS)) begin
            cells_clamped = CNT_W'(MESH_CELLS);
        end else begin
            cells_clamped = r_cells;
        end
        cells_minus1 = cells_clamped - CNT_W'(1);
    end

    // The current level is read one cell ahead of the cell being computed.
    assign cur_raddr = (r_state == ST_PRIME) ? '0 : r_idx + IDX_W'(1);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_last_idx  = r_last_idx;
        n_started   = r_started;
        n_out_valid = 1'b0;
        n_out       = r_out;
        ctl           = '0;
        ctl.first     = !r_started;
        ctl.mir_left  = (r_idx == '0) && left_neu;
        ctl.mir_right = at_last && right_neu;
        ctl.mur_right = at_last;
        cur_we    = 1'b0;
        cur_waddr = r_idx;
        cur_wdata = calc_nv;
        old_we    = 1'b0;
        ld_we     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_item.command == CMD_STEP) begin
                        n_state    = ST_PRIME;
                        n_idx      = '0;
                        n_last_idx = cells_minus1[IDX_W-1:0];
                    end else begin
                        // A load stores one cell and forces a start step next.
                        ld_we     = 1'b1;
                        cur_we    = 1'b1;
                        cur_waddr = i_item.cell_index;
                        cur_wdata = i_item.displacement;
                        n_started = 1'b0;
                    end
                end
            end
            ST_PRIME: begin
                n_state = ST_LOAD0;
            end
            ST_LOAD0: begin
                ctl.prime = 1'b1;
                n_state   = ST_FETCH;
            end
            ST_FETCH: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                ctl.mul = 1'b1;
                n_state = ST_FLUX;
            end
            ST_FLUX: begin
                ctl.flux = 1'b1;
                n_state  = ST_SCALE;
            end
            ST_SCALE: begin
                ctl.scale = 1'b1;
                n_state   = ST_SUM;
            end
            ST_SUM: begin
                ctl.sum = 1'b1;
                n_state = ST_SAT;
            end
            ST_SAT: begin
                ctl.sat     = 1'b1;
                ctl.zero_nv = ((r_idx == '0) && !left_neu) || (at_last && !right_neu);
                if ((at_last && right_mur) || ((r_idx == IDX_W'(1)) && left_mur)) begin
                    n_state = ST_MUR0;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_MUR0: begin
                ctl.mur0 = 1'b1;
                n_state  = ST_MUR1;
            end
            ST_MUR1: begin
                ctl.mur1 = 1'b1;
                n_state  = ST_MUR2;
            end
            ST_MUR2: begin
                if (at_last) begin
                    ctl.load_mur = 1'b1;
                end else begin
                    cur_we          = 1'b1;
                    cur_waddr       = '0;
                    cur_wdata       = calc_mur;
                    n_out_valid     = 1'b1;
                    n_out.out_index = '0;
                    n_out.new_value = calc_mur;
                    n_out.last      = 1'b0;
                end
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                old_we        = 1'b1;
                ctl.keep_prev = 1'b1;
                if (!skip_emit) begin
                    cur_we          = 1'b1;
                    n_out_valid     = 1'b1;
                    n_out.out_index = r_idx;
                    n_out.new_value = calc_nv;
                    n_out.last      = at_last;
                end
                if (at_last) begin
                    n_state   = ST_IDLE;
                    n_started = 1'b1;
                end else begin
                    ctl.shift = 1'b1;
                    n_idx     = r_idx + IDX_W'(1);
                    n_state   = ST_FETCH;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_last_idx  <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_last_idx  <= n_last_idx;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells      <= CNT_W'(MESH_CELLS);
            r_courant_sq <= '0;
            r_time_step  <= '0;
            r_mur_ratio  <= '0;
            r_left_mode  <= MODE_DIRICHLET;
            r_right_mode <= MODE_DIRICHLET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_CELLS_IN_USE: r_cells      <= i_cfg_data[CNT_W-1:0];
                REG_COURANT_SQ:   r_courant_sq <= i_cfg_data[16:0];
                REG_TIME_STEP:    r_time_step  <= i_cfg_data[15:0];
                REG_MUR_RATIO:    r_mur_ratio  <= $signed(i_cfg_data[17:0]);
                REG_LEFT_MODE:    r_left_mode  <= i_cfg_data[1:0];
                REG_RIGHT_MODE:   r_right_mode <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    wls_ram #(.WIDTH(VAL_W)) u_cur_ram (
        .i_clk   (i_clk),
        .i_we    (cur_we),
        .i_waddr (cur_waddr),
        .i_wdata (cur_wdata),
        .i_raddr (cur_raddr),
        .o_rdata (cur_q)
    );

    wls_ram #(.WIDTH(VAL_W)) u_old_ram (
        .i_clk   (i_clk),
        .i_we    (old_we),
        .i_waddr (r_idx),
        .i_wdata (calc_u),
        .i_raddr (r_idx),
        .o_rdata (old_q)
    );

    wls_ram #(.WIDTH(SPD_W)) u_spd_ram (
        .i_clk   (i_clk),
        .i_we    (ld_we),
        .i_waddr (i_item.cell_index),
        .i_wdata (i_item.node_speed_sq),
        .i_raddr (cur_raddr),
        .o_rdata (spd_q)
    );

    wls_ram #(.WIDTH(VAL_W)) u_vel_ram (
        .i_clk   (i_clk),
        .i_we    (ld_we),
        .i_waddr (i_item.cell_index),
        .i_wdata (i_item.initial_velocity),
        .i_raddr (r_idx),
        .o_rdata (vel_q)
    );

    wls_calc u_calc (
        .i_clk        (i_clk),
        .i_ctl        (ctl),
        .i_courant_sq (r_courant_sq),
        .i_time_step  (r_time_step),
        .i_mur_ratio  (r_mur_ratio),
        .i_cur_q      ($signed(cur_q)),
        .i_spd_q      (spd_q),
        .i_old_q      ($signed(old_q)),
        .i_vel_q      ($signed(vel_q)),
        .o_nv         (calc_nv),
        .o_mur_val    (calc_mur),
        .o_cell_u     (calc_u)
    );

    assign busy            = (r_state != ST_IDLE);
    assign o_cfg_ready     = !busy;
    assign o_result_strobe = r_out_valid;
    assign o_result        = r_out;

`ifndef SYNTHESIS
    a_strobe_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(busy))
        else $error("result transaction without a step in progress");

    a_last_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_result.last) |-> (o_result.out_index == r_last_idx))
        else $error("last flag on a cell other than the final one");

    a_step_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PRIME) |-> $past(r_state == ST_IDLE && start))
        else $error("step began without an accepted command");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_idx <= r_last_idx))
        else $error("cell pointer ran past the final cell");
`endif

endmodule

### verif/tb.sv
// Self-checking testbench for the 1D leapfrog wave stepper.
// Holds a scoreboard class with its own model of the mesh and drives the
// command, configuration and reset ports. Depends on wls_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
    import wls_pkg::*;

    // Scoreboard: keeps its own copy of the registers and the four level
    // memories, and turns each accepted transaction into the expected cell
    // values of the step that it causes.
    class wave_scoreboard;
        int unsigned     reg_cells;
        longint          reg_courant;
        longint          reg_dt;
        longint          reg_mur;
        logic [1:0]      reg_left;
        logic [1:0]      reg_right;
        longint          prev_lvl [MESH_CELLS];
        longint          cur_lvl [MESH_CELLS];
        longint          speed [MESH_CELLS];
        longint          vel [MESH_CELLS];
        bit              stepped;
        t_out_item       expected_cells [$];
        int              errors;

        function void clear();
            reg_cells = 64;
            reg_courant = 0;
            reg_dt = 0;
            reg_mur = 0;
            reg_left = MODE_DIRICHLET;
            reg_right = MODE_DIRICHLET;
            foreach (cur_lvl[k]) begin
                prev_lvl[k] = 0;
                cur_lvl[k] = 0;
                speed[k] = 0;
                vel[k] = 0;
            end
            stepped = 0;
            expected_cells.delete();
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_CELLS_IN_USE: reg_cells = 32'(data[6:0]);
                REG_COURANT_SQ:   reg_courant = 64'(data[16:0]);
                REG_TIME_STEP:    reg_dt = 64'(data[15:0]);
                REG_MUR_RATIO:    reg_mur = 64'($signed(data[17:0]));
                REG_LEFT_MODE:    reg_left = data[1:0];
                REG_RIGHT_MODE:   reg_right = data[1:0];
                default: ;
            endcase
        endfunction

        function int unsigned cells_used();
            int unsigned n;
            n = reg_cells;
            if (n < MIN_CELLS) n = MIN_CELLS;
            if (n > MESH_CELLS) n = MESH_CELLS;
            return n;
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint round16(longint a, longint b);
            return (a * b + 32768) >>> 16;
        endfunction

        // K*F scaled down without overflowing 64 bits: split F at bit 9.
        function longint courant_term(longint f, int fs);
            longint lo, hi, v;
            lo = f & 511;
            hi = f >>> 9;
            v = hi * reg_courant + ((lo * reg_courant) >>> 9) + (64'sd1 <<< (fs - 1));
            return v >>> fs;
        endfunction

        function longint stencil(longint um, longint u, longint up, longint sm,
                                 longint s, longint sp, int i);
            longint f, v;
            f = (s + sp) * (up - u) - (sm + s) * (u - um);
            if (!stepped)
                v = u + round16(reg_dt, vel[i]) + courant_term(f, 17);
            else
                v = 2 * u - prev_lvl[i] + courant_term(f, 16);
            return clip32(v);
        endfunction

        function void note_input(t_in_item it);
            longint nv [MESH_CELLS];
            int unsigned n, e;
            t_out_item r;
            if (it.command == CMD_LOAD) begin
                cur_lvl[it.cell_index] = 64'(it.displacement);
                vel[it.cell_index] = 64'(it.initial_velocity);
                speed[it.cell_index] = 64'(it.node_speed_sq);
                stepped = 0;
                return;
            end
            n = cells_used();
            e = n - 1;
            for (int i = 1; i < e; i++)
                nv[i] = stencil(cur_lvl[i-1], cur_lvl[i], cur_lvl[i+1],
                                speed[i-1], speed[i], speed[i+1], i);
            if (reg_left == MODE_NEUMANN)
                nv[0] = stencil(cur_lvl[1], cur_lvl[0], cur_lvl[1],
                                speed[1], speed[0], speed[1], 0);
            else if (reg_left == MODE_MUR)
                nv[0] = clip32(cur_lvl[1] + round16(reg_mur, nv[1] - cur_lvl[0]));
            else
                nv[0] = 0;
            if (reg_right == MODE_NEUMANN)
                nv[e] = stencil(cur_lvl[e-1], cur_lvl[e], cur_lvl[e-1],
                                speed[e-1], speed[e], speed[e-1], e);
            else if (reg_right == MODE_MUR)
                nv[e] = clip32(cur_lvl[e-1] + round16(reg_mur, nv[e-1] - cur_lvl[e]));
            else
                nv[e] = 0;
            for (int i = 0; i < n; i++) begin
                r.out_index = IDX_W'(i);
                r.new_value = nv[i][31:0];
                r.last = (i == e);
                expected_cells.push_back(r);
                prev_lvl[i] = cur_lvl[i];
                cur_lvl[i] = nv[i];
            end
            stepped = 1;
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %0s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check(t_out_item got);
            t_out_item want;
            if (expected_cells.size() == 0) begin
                report("unexpected result, index", got.out_index, -1);
                return;
            end
            want = expected_cells.pop_front();
            if (got.out_index !== want.out_index)
                report("out_index", got.out_index, want.out_index);
            if (got.new_value !== want.new_value)
                report("new_value", got.new_value, want.new_value);
            if (got.last !== want.last)
                report("last", got.last, want.last);
        endtask
    endclass

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  start = 0;
    t_in_item              i_item = '0;
    logic                  busy;
    logic                  o_result_strobe;
    t_out_item             o_result;
    logic                  i_cfg_valid = 0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    wave_scoreboard sb = new();
    int unsigned    cycles = 0;
    int unsigned    items_sent = 0;

    wave_1d_leapfrog_stepper uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_item(i_item),
        .busy(busy), .o_result_strobe(o_result_strobe), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Results cannot be held off, so every strobed cycle is checked at once.
    // Values are read right after the edge, before the design updates them.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe) sb.check(o_result);
    end

    // Watchdog: even with steps over 64 cells, a few hundred transactions
    // finish far below this bound.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Sends one transaction. A random gap before it drops start; with no gap,
    // start stays high from the previous transaction so they go back to back.
    task send(t_in_item it);
        int unsigned gap;
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sb.note_input(it);
        items_sent++;
    endtask

    // Lowers start and waits until every expected cell has come out and the
    // block is idle, then a little longer so that configuration is safe.
    task drain();
        start <= 1'b0;
        do @(posedge i_clk); while (busy || sb.expected_cells.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    task configure(logic [31:0] cells, logic [31:0] k, logic [31:0] dt,
                   logic [31:0] r, logic [31:0] lm, logic [31:0] rm);
        write_reg(REG_CELLS_IN_USE, cells);
        write_reg(REG_COURANT_SQ, k);
        write_reg(REG_TIME_STEP, dt);
        write_reg(REG_MUR_RATIO, r);
        write_reg(REG_LEFT_MODE, lm);
        write_reg(REG_RIGHT_MODE, rm);
        @(posedge i_clk);
    endtask

    // Mostly moderate values so that the waves evolve, now and then the
    // full range so that saturation and every bit are reached.
    function logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return 32'h7FFFFFFF;
            2: return 32'h80000000;
            default: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF;
        endcase
    endfunction

    function t_in_item load_item(int unsigned idx);
        t_in_item it;
        it.command = CMD_LOAD;
        it.cell_index = IDX_W'(idx);
        it.displacement = pick_value();
        it.initial_velocity = pick_value();
        it.node_speed_sq = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                       : 16'($urandom_range(0, 512));
        return it;
    endfunction

    function t_in_item step_item();
        t_in_item it;
        it.command = CMD_STEP;
        it.cell_index = IDX_W'($urandom());
        it.displacement = $urandom();
        it.initial_velocity = $urandom();
        it.node_speed_sq = 16'($urandom());
        return it;
    endfunction

    // Fills every cell in use; a load also makes the next step a first step.
    task load_mesh();
        for (int i = 0; i < sb.cells_used(); i++) send(load_item(i));
    endtask

    task directed_extremes(int unsigned n);
        t_in_item it;
        for (int i = 0; i < n; i++) begin
            it = load_item(i);
            it.displacement = (i % 2) ? 32'h80000000 : 32'h7FFFFFFF;
            it.initial_velocity = (i % 2) ? 32'h7FFFFFFF : 32'h80000000;
            it.node_speed_sq = (i % 2) ? 16'h0000 : 16'hFFFF;
            send(it);
        end
    endtask

    initial begin
        int unsigned n, lm, rm, steps;
        logic [31:0] cells, k, r;
        sb.clear();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: saturating extremes with Neumann on the left and Mur on
        // the right, a Mur ratio of -65536, full Courant factor.
        configure(5, 65536, 65535, 32'h3_0000, 32'(MODE_NEUMANN), 32'(MODE_MUR));
        directed_extremes(5);
        send(step_item());
        send(step_item());
        // A load after steps restarts with the half-step formula.
        send(load_item(2));
        send(step_item());
        drain();

        // Smallest mesh (a count below the minimum clamps to three), the
        // unused mode code on the left, a Mur ratio of 65536.
        configure(0, 0, 0, 65536, 3, 32'(MODE_NEUMANN));
        load_mesh();
        send(step_item());
        send(step_item());
        drain();
        configure(2, 40000, 30000, 32'hFFFF_0000, 32'(MODE_MUR), 3);
        load_mesh();
        send(step_item());
        send(step_item());
        drain();

        // Random phases; the first uses a count above the mesh (clamps to
        // the full 64 cells) so every index bit is exercised.
        for (int ph = 0; items_sent < 360; ph++) begin
            case ($urandom_range(0, 5))
                0: cells = $urandom_range(65, 127);
                1: cells = $urandom_range(13, 64);
                default: cells = $urandom_range(3, 12);
            endcase
            if (ph == 0) cells = 100;
            k = ($urandom_range(0, 4) == 0) ? 65536 : $urandom_range(0, 16000);
            r = $urandom_range(0, 131072) - 65536;
            r[31:18] = 14'($urandom());
            lm = $urandom_range(0, 3);
            rm = $urandom_range(0, 3);
            configure(cells | ($urandom() & 32'hFFFF_FF80), k, $urandom_range(0, 65535),
                      r, lm, rm);
            n = sb.cells_used();
            load_mesh();
            steps = $urandom_range(2, 6);
            for (int s = 0; s < steps; s++) begin
                // Now and then reload a cell in the middle of a run.
                if ($urandom_range(0, 4) == 0) send(load_item($urandom_range(0, n - 1)));
                send(step_item());
            end
            drain();
        end

        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_cells.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
